FILE: rtl/vrt_pkg.sv
`default_nettype none
package vrt_pkg;

    localparam int unsigned CELL_W   = 20;
    localparam int unsigned FACE_W   = 2;
    localparam int unsigned ORG_W    = 32;
    localparam int unsigned DIR_W    = 16;
    localparam int unsigned MAXD_W   = 14;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned S_DATA_W = 144;
    localparam int unsigned M_DATA_W = 72;

    localparam logic [MAXD_W-1:0] MAXD_RESET = 14'd2560;
    localparam logic [CNT_W-1:0]  CNT_LAST   = 6'd63;
    localparam logic [FACE_W-1:0] FACE_NONE  = 2'b00;
    localparam logic [FACE_W-1:0] FACE_POS   = 2'b01;
    localparam logic [FACE_W-1:0] FACE_NEG   = 2'b11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DRAIN,
        ST_SELECT,
        ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_LEN0, OP_LEN1, OP_LEN2,
        OP_Q01, OP_Q10, OP_Q02, OP_Q20, OP_Q12, OP_Q21,
        OP_X0, OP_X1, OP_X2,
        OP_R0, OP_R1, OP_R2,
        OP_T0, OP_T1, OP_T2,
        OP_SL0, OP_SL1, OP_SL2,
        OP_SH0, OP_SH1, OP_SH2
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_en;
        op_t  op;
        logic select;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/vrt_ctrl.sv
`default_nettype none
module vrt_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output vrt_pkg::dp_cmd_t      cmd,
    input  vrt_pkg::dp_stat_t     stat
);
    import vrt_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_LEN0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE: begin
                op_next = OP_LEN0;
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (op_reg == OP_SH2) begin
                    state_next = ST_DRAIN;
                end else begin
                    op_next = op_t'(5'(op_reg) + 5'd1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    state_next = stat.last ? ST_IDLE : ST_SELECT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.load    = 1'b0;
        cmd.mul_en  = 1'b0;
        cmd.op      = op_reg;
        cmd.select  = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SETUP: begin
                cmd.mul_en = 1'b1;
            end
            ST_SELECT: begin
                cmd.select = 1'b1;
            end
            ST_EMIT: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready & ~stat.last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/vrt_datapath.sv
`default_nettype none
module vrt_datapath #(
    parameter int unsigned POS_FRAC_BITS = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  vrt_pkg::dp_cmd_t                     cmd,
    output vrt_pkg::dp_stat_t                    stat,
    input  wire logic [vrt_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [vrt_pkg::MAXD_W-1:0]      cfg_wdata,
    output logic      [vrt_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                                 m_tlast
);
    import vrt_pkg::*;

    localparam int unsigned P  = POS_FRAC_BITS;
    localparam int unsigned AW = P + 7;
    localparam int unsigned QW = AW + DIR_W;
    localparam int unsigned TW = AW + 32;
    localparam int unsigned SW = 2 * AW + 32;
    localparam int unsigned XW = MAXD_W + DIR_W;
    localparam int unsigned RW = 2 * XW;
    localparam int unsigned CW = SW + 16;

    logic [MAXD_W-1:0]        maxd_reg;
    logic [CELL_W-1:0]        cell_reg [3];
    logic [FACE_W-1:0]        face_reg [3];
    logic                     neg_reg  [3];
    logic [DIR_W-1:0]         mag_reg  [3];
    logic [AW-1:0]            a_reg    [3];
    logic [31:0]              len2_reg;
    logic [QW-1:0]            q_reg    [6];
    logic [XW-1:0]            x_reg    [3];
    logic [RW-1:0]            r_reg    [3];
    logic [TW-1:0]            t_reg    [3];
    logic [SW-1:0]            s_reg    [3];
    logic [63:0]              prod_reg;
    logic                     wb_en_reg;
    op_t                      wb_op_reg;
    logic [1:0]               sel_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CELL_W-1:0]        ocell_reg [3];
    logic [FACE_W-1:0]        oface_reg [3];
    logic                     olast_reg;

    logic signed [ORG_W-1:0]  org      [3];
    logic signed [ORG_W-1:0]  org_sh   [3];
    logic [DIR_W-1:0]         dv       [3];
    logic [CELL_W-1:0]        ld_cell  [3];
    logic                     ld_neg   [3];
    logic [DIR_W-1:0]         ld_mag   [3];
    logic [AW-1:0]            ld_a     [3];
    logic [31:0]              mul_a, mul_b;
    logic                     n01, n02, n12;
    logic [1:0]               sel;
    logic                     beyond;
    logic [CW-1:0]            lhs, rhs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            org[i]     = $signed(s_tdata[ORG_W*i +: ORG_W]);
            dv[i]      = s_tdata[3*ORG_W + DIR_W*i +: DIR_W];
            org_sh[i]  = org[i] >>> P;
            ld_cell[i] = org_sh[i][CELL_W-1:0];
            ld_neg[i]  = dv[i][DIR_W-1];
            ld_mag[i]  = ld_neg[i] ? (~dv[i] + DIR_W'(1)) : dv[i];
            ld_a[i]    = ld_neg[i] ? AW'(org[i][P-1:0])
                                   : ((AW'(1) << P) - AW'(org[i][P-1:0]));
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_LEN0: begin mul_a = 32'(mag_reg[0]); mul_b = 32'(mag_reg[0]); end
            OP_LEN1: begin mul_a = 32'(mag_reg[1]); mul_b = 32'(mag_reg[1]); end
            OP_LEN2: begin mul_a = 32'(mag_reg[2]); mul_b = 32'(mag_reg[2]); end
            OP_Q01:  begin mul_a = 32'(a_reg[0]); mul_b = 32'(mag_reg[1]); end
            OP_Q10:  begin mul_a = 32'(a_reg[1]); mul_b = 32'(mag_reg[0]); end
            OP_Q02:  begin mul_a = 32'(a_reg[0]); mul_b = 32'(mag_reg[2]); end
            OP_Q20:  begin mul_a = 32'(a_reg[2]); mul_b = 32'(mag_reg[0]); end
            OP_Q12:  begin mul_a = 32'(a_reg[1]); mul_b = 32'(mag_reg[2]); end
            OP_Q21:  begin mul_a = 32'(a_reg[2]); mul_b = 32'(mag_reg[1]); end
            OP_X0:   begin mul_a = 32'(maxd_reg); mul_b = 32'(mag_reg[0]); end
            OP_X1:   begin mul_a = 32'(maxd_reg); mul_b = 32'(mag_reg[1]); end
            OP_X2:   begin mul_a = 32'(maxd_reg); mul_b = 32'(mag_reg[2]); end
            OP_R0:   begin mul_a = 32'(x_reg[0]); mul_b = 32'(x_reg[0]); end
            OP_R1:   begin mul_a = 32'(x_reg[1]); mul_b = 32'(x_reg[1]); end
            OP_R2:   begin mul_a = 32'(x_reg[2]); mul_b = 32'(x_reg[2]); end
            OP_T0:   begin mul_a = 32'(a_reg[0]); mul_b = len2_reg; end
            OP_T1:   begin mul_a = 32'(a_reg[1]); mul_b = len2_reg; end
            OP_T2:   begin mul_a = 32'(a_reg[2]); mul_b = len2_reg; end
            OP_SL0:  begin mul_a = 32'(a_reg[0]); mul_b = t_reg[0][31:0]; end
            OP_SL1:  begin mul_a = 32'(a_reg[1]); mul_b = t_reg[1][31:0]; end
            OP_SL2:  begin mul_a = 32'(a_reg[2]); mul_b = t_reg[2][31:0]; end
            OP_SH0:  begin mul_a = 32'(a_reg[0]); mul_b = 32'(t_reg[0][TW-1:32]); end
            OP_SH1:  begin mul_a = 32'(a_reg[1]); mul_b = 32'(t_reg[1][TW-1:32]); end
            OP_SH2:  begin mul_a = 32'(a_reg[2]); mul_b = 32'(t_reg[2][TW-1:32]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // nearer axis: zero magnitude wins only when all three magnitudes are zero
    always_comb begin
        n01 = (mag_reg[0] != '0) && ((mag_reg[1] == '0) || (q_reg[0] < q_reg[1]));
        n02 = (mag_reg[0] != '0) && ((mag_reg[2] == '0) || (q_reg[2] < q_reg[3]));
        n12 = (mag_reg[1] != '0) && ((mag_reg[2] == '0) || (q_reg[4] < q_reg[5]));
        sel = n01 ? (n02 ? 2'd0 : 2'd2) : (n12 ? 2'd1 : 2'd2);
        lhs = CW'(s_reg[sel]) << 16;
        rhs = CW'(r_reg[sel]) << (2 * P);
        beyond = (mag_reg[sel] == '0) || (lhs > rhs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maxd_reg  <= MAXD_RESET;
            wb_en_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                maxd_reg <= cfg_wdata;
            end
            wb_en_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= 64'(mul_a) * 64'(mul_b);
        wb_op_reg <= cmd.op;

        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                cell_reg[i] <= ld_cell[i];
                face_reg[i] <= FACE_NONE;
                neg_reg[i]  <= ld_neg[i];
                mag_reg[i]  <= ld_mag[i];
                a_reg[i]    <= ld_a[i];
            end
            len2_reg <= '0;
            cnt_reg  <= '0;
        end

        if (wb_en_reg) begin
            case (wb_op_reg)
                OP_LEN0, OP_LEN1, OP_LEN2: len2_reg <= len2_reg + prod_reg[31:0];
                OP_Q01: q_reg[0] <= prod_reg[QW-1:0];
                OP_Q10: q_reg[1] <= prod_reg[QW-1:0];
                OP_Q02: q_reg[2] <= prod_reg[QW-1:0];
                OP_Q20: q_reg[3] <= prod_reg[QW-1:0];
                OP_Q12: q_reg[4] <= prod_reg[QW-1:0];
                OP_Q21: q_reg[5] <= prod_reg[QW-1:0];
                OP_X0:  x_reg[0] <= prod_reg[XW-1:0];
                OP_X1:  x_reg[1] <= prod_reg[XW-1:0];
                OP_X2:  x_reg[2] <= prod_reg[XW-1:0];
                OP_R0:  r_reg[0] <= prod_reg[RW-1:0];
                OP_R1:  r_reg[1] <= prod_reg[RW-1:0];
                OP_R2:  r_reg[2] <= prod_reg[RW-1:0];
                OP_T0:  t_reg[0] <= prod_reg[TW-1:0];
                OP_T1:  t_reg[1] <= prod_reg[TW-1:0];
                OP_T2:  t_reg[2] <= prod_reg[TW-1:0];
                OP_SL0: s_reg[0] <= SW'(prod_reg);
                OP_SL1: s_reg[1] <= SW'(prod_reg);
                OP_SL2: s_reg[2] <= SW'(prod_reg);
                OP_SH0: s_reg[0] <= s_reg[0] + (SW'(prod_reg) << 32);
                OP_SH1: s_reg[1] <= s_reg[1] + (SW'(prod_reg) << 32);
                OP_SH2: s_reg[2] <= s_reg[2] + (SW'(prod_reg) << 32);
                default: len2_reg <= len2_reg;
            endcase
        end

        if (cmd.select) begin
            sel_reg   <= sel;
            olast_reg <= beyond || (cnt_reg == CNT_LAST);
            for (int i = 0; i < 3; i++) begin
                ocell_reg[i] <= cell_reg[i];
                oface_reg[i] <= face_reg[i];
            end
        end

        // step across the selected boundary
        if (cmd.advance) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            for (int i = 0; i < 3; i++) begin
                if (2'(i) == sel_reg) begin
                    face_reg[i] <= neg_reg[i] ? FACE_POS : FACE_NEG;
                end else begin
                    face_reg[i] <= FACE_NONE;
                end
            end
            cell_reg[sel_reg] <= neg_reg[sel_reg] ? cell_reg[sel_reg] - CELL_W'(1)
                                                  : cell_reg[sel_reg] + CELL_W'(1);
            a_reg[sel_reg] <= a_reg[sel_reg] + (AW'(1) << P);
            t_reg[sel_reg] <= t_reg[sel_reg] + (TW'(len2_reg) << P);
            s_reg[sel_reg] <= s_reg[sel_reg] + (SW'(t_reg[sel_reg]) << (P + 1))
                                             + (SW'(len2_reg) << (2 * P));
            case (sel_reg)
                2'd0: begin
                    q_reg[0] <= q_reg[0] + (QW'(mag_reg[1]) << P);
                    q_reg[2] <= q_reg[2] + (QW'(mag_reg[2]) << P);
                end
                2'd1: begin
                    q_reg[1] <= q_reg[1] + (QW'(mag_reg[0]) << P);
                    q_reg[4] <= q_reg[4] + (QW'(mag_reg[2]) << P);
                end
                default: begin
                    q_reg[3] <= q_reg[3] + (QW'(mag_reg[0]) << P);
                    q_reg[5] <= q_reg[5] + (QW'(mag_reg[1]) << P);
                end
            endcase
        end
    end

    assign stat.last = olast_reg;
    assign m_tlast   = olast_reg;
    assign m_tdata   = {6'd0, oface_reg[2], oface_reg[1], oface_reg[0],
                        ocell_reg[2], ocell_reg[1], ocell_reg[0]};

endmodule
`default_nettype wire

FILE: rtl/voxel_ray_traversal.sv
// voxel ray traversal
// s_ channel: one beat per ray, origin in signed fixed point with
// POS_FRAC_BITS fraction bits, direction in signed 16-bit fixed point.
// m_ channel: one beat per visited cell in walk order, with the normal of
// the face entered (zero on the first cell); m_tlast marks the final cell
// of the ray, which is the last one inside the max_distance limit or the
// 64th cell.
// cfg_we/cfg_wdata write max_distance (unsigned Q6.8); write only while idle.
// timing: a ray runs its setup products on one shared 32x32 multiplier, then
// each cell takes a select step and an output beat. a new ray is taken only
// after the last beat of the previous ray has been delivered.
// stall: m_tvalid and the beat hold while m_tready is low; the walk waits.
// reset: aresetn low for one clock returns to idle, drops any ray in work
// and sets max_distance to 10.0.
`default_nettype none
module voxel_ray_traversal #(
    parameter int unsigned POS_FRAC_BITS = 12
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  wire logic [vrt_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // cell_x, cell_y, cell_z, face_x, face_y, face_z, zero pad
    output logic      [vrt_pkg::M_DATA_W-1:0]   m_tdata,
    // last_cell
    output logic                                m_tlast,
    input  wire logic                           cfg_we,
    input  wire logic [vrt_pkg::MAXD_W-1:0]     cfg_wdata
);
    import vrt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    vrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vrt_datapath #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

FILE: dv/voxel_ray_checker.sv
`default_nettype none
module voxel_ray_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [vrt_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [vrt_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic                         m_tlast,
    input  wire logic                         cfg_we,
    input  wire logic [vrt_pkg::MAXD_W-1:0]   cfg_wdata,
    output int                                mismatch_count,
    output int                                cells_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import vrt_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0] cx, cy, cz;
        logic [FACE_W-1:0] fx, fy, fz;
        logic              last;
    } cell_beat_t;

    cell_beat_t       cell_q[$];
    logic [MAXD_W-1:0] limit_q88;
    int               beat_no;

    assign cells_pending = cell_q.size();

    function automatic logic is_nearer(logic [63:0] ai, logic [63:0] mi,
                                       logic [63:0] aj, logic [63:0] mj);
        if (mi == 0) return 1'b0;
        if (mj == 0) return 1'b1;
        return (ai * mj) < (aj * mi);
    endfunction

    function automatic logic past_limit(logic [63:0] a, logic [63:0] m, logic [127:0] len2);
        logic [127:0] x, y, lhs, rhs;
        if (m == 0) return 1'b1;
        x   = a * 256;
        y   = 128'(limit_q88) * 4096 * m;
        lhs = x * x * len2;
        rhs = y * y;
        return lhs > rhs;
    endfunction

    task automatic walk_ray(input logic [S_DATA_W-1:0] d);
        logic [CELL_W-1:0] c[3];
        logic [FACE_W-1:0] f[3];
        logic              ng[3];
        logic [63:0]       mg[3], a[3];
        logic [127:0]      len2;
        logic [31:0]       u;
        logic [15:0]       dv;
        int                n, sel;
        logic              done;
        cell_beat_t        b;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            u     = d[32*i +: 32];
            dv    = d[96+16*i +: 16];
            c[i]  = u[31:12];
            f[i]  = FACE_NONE;
            ng[i] = dv[15];
            mg[i] = ng[i] ? 64'h10000 - 64'(dv) : 64'(dv);
            a[i]  = ng[i] ? 64'(u[11:0]) : 64'd4096 - 64'(u[11:0]);
            len2 += 128'(mg[i] * mg[i]);
        end
        n = 0;
        done = 1'b0;
        while (!done) begin
            n++;
            if (is_nearer(a[0], mg[0], a[1], mg[1]))
                sel = is_nearer(a[0], mg[0], a[2], mg[2]) ? 0 : 2;
            else
                sel = is_nearer(a[1], mg[1], a[2], mg[2]) ? 1 : 2;
            done = past_limit(a[sel], mg[sel], len2) || n == 64;
            b = '{c[0], c[1], c[2], f[0], f[1], f[2], done};
            cell_q.push_back(b);
            if (!done) begin
                c[sel] = ng[sel] ? c[sel] - 1'b1 : c[sel] + 1'b1;
                for (int i = 0; i < 3; i++) f[i] = FACE_NONE;
                f[sel] = ng[sel] ? FACE_POS : FACE_NEG;
                a[sel] += 64'd4096;
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("beat %0d: %s got %0h expected %0h", beat_no, what, got, want);
        mismatch_count++;
    endtask

    initial begin
        mismatch_count = 0;
        beat_no        = 0;
        limit_q88      = MAXD_RESET;
    end

    always @(posedge aclk) begin
        cell_beat_t w;
        if (!aresetn) begin
            limit_q88 <= MAXD_RESET;
        end else begin
            if (cfg_we) limit_q88 <= cfg_wdata;
            if (s_tvalid && s_tready) walk_ray(s_tdata);
            if (m_tvalid && m_tready) begin
                if (cell_q.size() == 0) begin
                    report("cell with no ray pending", 32'(m_tdata[19:0]), 32'd0);
                end else begin
                    w = cell_q.pop_front();
                    if (m_tdata[19:0] !== w.cx)
                        report("cell_x", 32'(m_tdata[19:0]), 32'(w.cx));
                    if (m_tdata[39:20] !== w.cy)
                        report("cell_y", 32'(m_tdata[39:20]), 32'(w.cy));
                    if (m_tdata[59:40] !== w.cz)
                        report("cell_z", 32'(m_tdata[59:40]), 32'(w.cz));
                    if (m_tdata[61:60] !== w.fx)
                        report("face_x", 32'(m_tdata[61:60]), 32'(w.fx));
                    if (m_tdata[63:62] !== w.fy)
                        report("face_y", 32'(m_tdata[63:62]), 32'(w.fy));
                    if (m_tdata[65:64] !== w.fz)
                        report("face_z", 32'(m_tdata[65:64]), 32'(w.fz));
                    if (m_tlast !== w.last)
                        report("last_cell", 32'(m_tlast), 32'(w.last));
                end
                beat_no++;
            end
        end
    end
endmodule
`default_nettype wire

FILE: dv/tb_voxel_ray_traversal.sv
`default_nettype none
module tb_voxel_ray_traversal;
    timeunit 1ns;
    timeprecision 1ps;
    import vrt_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [MAXD_W-1:0]     cfg_wdata = '0;
    int                    mismatch_count, cells_pending;
    int                    idle_cycles = 0;
    int                    beats_taken = 0;
    logic                  burst = 1'b0;

    always #2 aclk = ~aclk;

    voxel_ray_traversal u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    voxel_ray_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .mismatch_count(mismatch_count), .cells_pending(cells_pending)
    );

    // watchdog on accepted beats
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == 3000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver with random stalls, one long hold-off
    initial begin
        int wait_n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (beats_taken == 900) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            wait_n = ((beats_taken / 150) % 3 == 2) ? 0 : $urandom_range(0, 3);
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            beats_taken++;
        end
    end

    task automatic send_ray(input logic [31:0] ox, oy, oz, input logic [15:0] dx, dy, dz);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dz, dy, dx, oz, oy, ox};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic settle_and_write(input logic [MAXD_W-1:0] v);
        s_tvalid <= 1'b0;
        while (cells_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_ray();
        logic [31:0] o[3];
        logic [15:0] d[3];
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 3))
                0: o[i] = $urandom;
                1: o[i] = {20'($signed($urandom_range(0, 40)) - 20), 12'($urandom)};
                2: o[i] = {20'($urandom), 12'h000};
                default: o[i] = {20'($urandom_range(0, 8)), 12'($urandom)};
            endcase
            case ($urandom_range(0, 7))
                0: d[i] = 16'h0000;
                1: d[i] = 16'h8000;
                2: d[i] = 16'h7fff;
                3: d[i] = 16'($signed($urandom_range(0, 64)) - 32);
                default: d[i] = 16'($urandom);
            endcase
        end
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    initial begin
        logic [MAXD_W-1:0] limits[6];
        limits = '{14'd0, 14'h3fff, 14'd256, 14'd9216, 14'd1024, 14'd2560};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rays at the reset limit, then at the largest and zero limits
        send_ray(32'h0000_0800, 32'h0000_0800, 32'h0000_0800, 16'h0000, 16'h0000, 16'h0000);
        send_ray(32'h0000_0800, 32'h0000_0800, 32'h0000_0800, 16'h4000, 16'h0000, 16'h0000);
        send_ray(32'h0000_0800, 32'h0000_0800, 32'h0000_0800, 16'h0000, 16'hc000, 16'h0000);
        send_ray(32'h0000_0800, 32'h0000_0800, 32'h0000_0800, 16'h0000, 16'h0000, 16'h4000);
        send_ray(32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 16'h4000, 16'h4000, 16'h4000);
        send_ray(32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 16'hc000, 16'hc000, 16'hc000);
        send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h2000, 16'hc000, 16'h2000);
        send_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_f000, 16'h7fff, 16'h8000, 16'h7fff);
        send_ray(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'h8000, 16'h7fff, 16'h0001);
        send_ray(32'hffff_f800, 32'h0000_0400, 32'h0000_0c00, 16'h0001, 16'hffff, 16'h0000);
        send_ray(32'h0001_2345, 32'hfffe_dcba, 32'h0000_0fff, 16'h1234, 16'hedcb, 16'h0f0f);
        settle_and_write(14'h3fff);
        send_ray(32'h0000_0001, 32'h0000_0fff, 32'h0000_0800, 16'h7fff, 16'h7fff, 16'h7fff);
        send_ray(32'h0000_0800, 32'h0000_0800, 32'h0000_0800, 16'h0001, 16'h0000, 16'h0000);
        settle_and_write(14'd0);
        send_ray(32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 16'hc000, 16'hc000, 16'hc000);
        send_ray(32'h0000_1000, 32'h0000_2800, 32'h0000_3000, 16'h4000, 16'hc000, 16'hc000);
        send_ray(32'h0000_0800, 32'h0000_0800, 32'h0000_0800, 16'h4000, 16'h4000, 16'h4000);

        // random phases over several limits
        for (int p = 0; p < 6; p++) begin
            settle_and_write(limits[p]);
            for (int k = 0; k < 49; k++) begin
                burst = (k >= 30 && k < 40);
                random_ray();
            end
        end
        burst = 1'b0;
        settle_and_write(14'($urandom));
        for (int k = 0; k < 10; k++) random_ray();

        s_tvalid <= 1'b0;
        while (cells_pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (mismatch_count == 0 && cells_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
